// ===== hdl/srfp_pkg.sv =====
// Shared types and constants for the servo reply frame parser.
package srfp_pkg;

	localparam logic [7:0] HDR_FIRST  = 8'h05;
	localparam logic [7:0] HDR_SECOND = 8'h1C;

	localparam logic ACTION_BYTE = 1'b0;
	localparam logic ACTION_TICK = 1'b1;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_STATUS  = 1'b1;

	localparam logic [1:0] STATUS_OK       = 2'd0;
	localparam logic [1:0] STATUS_CMD_ERR  = 2'd1;
	localparam logic [1:0] STATUS_CSUM_ERR = 2'd2;
	localparam logic [1:0] STATUS_TIMEOUT  = 2'd3;

	localparam logic REG_EXPECTED_CMD = 1'b0;
	localparam logic REG_TIMEOUT      = 1'b1;

	localparam logic [15:0] TIMEOUT_RESET = 16'd100;

	typedef enum logic [2:0] {
		ST_HUNT    = 3'd0,
		ST_HDR2    = 3'd1,
		ST_CMD     = 3'd2,
		ST_LEN     = 3'd3,
		ST_PAYLOAD = 3'd4,
		ST_CSUM    = 3'd5
	} parse_step_t;

	typedef struct packed {
		logic       valid;
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [1:0] status;
		logic [7:0] command;
		logic [7:0] length;
	} result_t;

endpackage

// ===== hdl/srfp_core.sv =====
// Frame parsing state machine, checksum and tick timer of the reply parser.
module srfp_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 step_en,
	input  logic                 action,
	input  logic [7:0]           data_byte,
	input  logic [7:0]           expected_command,
	input  logic [15:0]          timeout_ticks,
	output srfp_pkg::result_t    result
);

	srfp_pkg::parse_step_t step_q, step_d;
	logic [7:0]  cmd_q, cmd_d;
	logic [7:0]  len_q, len_d;
	logic [7:0]  count_q, count_d;
	logic [7:0]  sum_q, sum_d;
	logic [15:0] elapsed_q, elapsed_d;
	logic [15:0] tick_elapsed;
	logic        tick_timeout;
	logic [7:0]  count_inc;

	assign tick_elapsed = (elapsed_q < timeout_ticks) ? elapsed_q + 16'd1 : elapsed_q;
	assign tick_timeout = (tick_elapsed >= timeout_ticks);
	assign count_inc    = count_q + 8'd1;

	always_comb begin
		step_d    = step_q;
		cmd_d     = cmd_q;
		len_d     = len_q;
		count_d   = count_q;
		sum_d     = sum_q;
		elapsed_d = elapsed_q;
		if (action == srfp_pkg::ACTION_TICK) begin
			elapsed_d = tick_elapsed;
			if (tick_timeout) begin
				step_d    = srfp_pkg::ST_HUNT;
				cmd_d     = '0;
				len_d     = '0;
				count_d   = '0;
				sum_d     = '0;
				elapsed_d = '0;
			end
		end else begin
			unique case (step_q)
				srfp_pkg::ST_HDR2: begin
					if (data_byte == srfp_pkg::HDR_SECOND) begin
						sum_d  = sum_q + data_byte;
						step_d = srfp_pkg::ST_CMD;
					end else begin
						step_d = srfp_pkg::ST_HUNT;
					end
				end
				srfp_pkg::ST_CMD: begin
					cmd_d  = data_byte;
					sum_d  = sum_q + data_byte;
					step_d = srfp_pkg::ST_LEN;
				end
				srfp_pkg::ST_LEN: begin
					len_d   = data_byte;
					sum_d   = sum_q + data_byte;
					count_d = '0;
					step_d  = (data_byte != 8'd0) ? srfp_pkg::ST_PAYLOAD : srfp_pkg::ST_CSUM;
				end
				srfp_pkg::ST_PAYLOAD: begin
					sum_d   = sum_q + data_byte;
					count_d = count_inc;
					if (count_inc >= len_q) begin
						step_d = srfp_pkg::ST_CSUM;
					end
				end
				srfp_pkg::ST_CSUM: begin
					step_d    = srfp_pkg::ST_HUNT;
					cmd_d     = '0;
					len_d     = '0;
					count_d   = '0;
					sum_d     = '0;
					elapsed_d = '0;
				end
				default: begin
					if (data_byte == srfp_pkg::HDR_FIRST) begin
						cmd_d   = '0;
						len_d   = '0;
						count_d = '0;
						sum_d   = data_byte;
						step_d  = srfp_pkg::ST_HDR2;
					end else begin
						step_d = srfp_pkg::ST_HUNT;
					end
				end
			endcase
		end
	end

	always_comb begin
		result         = '0;
		result.command = cmd_q;
		result.length  = len_q;
		if (action == srfp_pkg::ACTION_TICK) begin
			result.valid  = tick_timeout;
			result.kind   = srfp_pkg::KIND_STATUS;
			result.status = srfp_pkg::STATUS_TIMEOUT;
		end else begin
			unique case (step_q)
				srfp_pkg::ST_PAYLOAD: begin
					result.valid         = 1'b1;
					result.kind          = srfp_pkg::KIND_PAYLOAD;
					result.payload_byte  = data_byte;
					result.payload_index = count_q;
				end
				srfp_pkg::ST_CSUM: begin
					result.valid = 1'b1;
					result.kind  = srfp_pkg::KIND_STATUS;
					if (sum_q != data_byte) begin
						result.status = srfp_pkg::STATUS_CSUM_ERR;
					end else if (cmd_q == expected_command) begin
						result.status = srfp_pkg::STATUS_OK;
					end else begin
						result.status = srfp_pkg::STATUS_CMD_ERR;
					end
				end
				default: begin
					result.valid = 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q    <= srfp_pkg::ST_HUNT;
			cmd_q     <= '0;
			len_q     <= '0;
			count_q   <= '0;
			sum_q     <= '0;
			elapsed_q <= '0;
		end else if (step_en) begin
			step_q    <= step_d;
			cmd_q     <= cmd_d;
			len_q     <= len_d;
			count_q   <= count_d;
			sum_q     <= sum_d;
			elapsed_q <= elapsed_d;
		end
	end

endmodule

// ===== hdl/servo_reply_frame_parser.sv =====
// Top level of the servo reply frame parser with input stage, result register and APB registers.
// Each input beat is one received byte or one millisecond tick; the parser accepts a beat
// every cycle while in_stall is low, and a beat leaves the input register when the core
// advances on it, which it does as long as results are taken. The frame state machine, additive checksum
// and tick timer all update together as the beat moves from the input register into the result
// register. A beat that yields a result waits in the input register only while the result
// register is full and stalled. Registers: expected_command at 0x0, timeout_ticks at 0x4.
module servo_reply_frame_parser (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [2:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        action,
	input  logic [7:0]  data_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  payload_byte,
	output logic [7:0]  payload_index,
	output logic [1:0]  status,
	output logic [7:0]  command,
	output logic [7:0]  length
);

	logic [7:0]  expected_cmd_q;
	logic [15:0] timeout_q;
	logic        reg_sel;
	logic        valid_s1;
	logic        action_s1;
	logic [7:0]  data_s1;
	logic        out_free;
	logic        advance;
	logic        in_take;
	srfp_pkg::result_t res;

	assign pready  = 1'b1;
	assign reg_sel = paddr[2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_cmd_q <= '0;
			timeout_q      <= srfp_pkg::TIMEOUT_RESET;
		end else if (psel && penable && pwrite && pready) begin
			if (reg_sel == srfp_pkg::REG_EXPECTED_CMD) begin
				expected_cmd_q <= pwdata[7:0];
			end else begin
				timeout_q <= pwdata[15:0];
			end
		end
	end

	always_comb begin
		if (reg_sel == srfp_pkg::REG_TIMEOUT) begin
			prdata = {16'd0, timeout_q};
		end else begin
			prdata = {24'd0, expected_cmd_q};
		end
	end

	assign out_free = !out_valid || !out_stall;
	assign advance  = valid_s1 && (!res.valid || out_free);
	assign in_stall = valid_s1 && !advance;
	assign in_take  = in_valid && !in_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			action_s1 <= action;
			data_s1   <= data_byte;
		end
	end

	srfp_core u_core (
		.clk              (clk),
		.arst_n           (arst_n),
		.step_en          (advance),
		.action           (action_s1),
		.data_byte        (data_s1),
		.expected_command (expected_cmd_q),
		.timeout_ticks    (timeout_q),
		.result           (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance && res.valid) begin
			out_valid <= 1'b1;
		end else if (!out_stall) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && res.valid) begin
			kind          <= res.kind;
			payload_byte  <= res.payload_byte;
			payload_index <= res.payload_index;
			status        <= res.status;
			command       <= res.command;
			length        <= res.length;
		end
	end

	a_stall_only_when_held: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && res.valid && out_valid && out_stall))
		else $error("input stalled without a blocked result");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && res.valid) |=> out_valid)
		else $error("result lost on its way to the output register");

	a_payload_status_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == srfp_pkg::KIND_PAYLOAD) |-> (status == srfp_pkg::STATUS_OK))
		else $error("payload beat carries a status");

endmodule

// ===== sim/tb_servo_reply_frame_parser.sv =====
// Self-checking testbench for the servo reply frame parser with a built-in frame predictor.
module tb_servo_reply_frame_parser;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WATCHDOG_LIMIT = 20000;
	localparam int DRAIN_CYCLES   = 8;

	typedef struct packed {
		logic       action;
		logic [7:0] data;
	} rx_beat_t;

	typedef struct packed {
		logic       kind;
		logic [7:0] payload_byte;
		logic [7:0] payload_index;
		logic [1:0] status;
		logic [7:0] command;
		logic [7:0] length;
	} reply_t;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [2:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic        in_valid  = 1'b0;
	logic        action    = srfp_pkg::ACTION_BYTE;
	logic [7:0]  data_byte = '0;
	logic        out_stall = 1'b0;
	logic [31:0] prdata;
	logic        pready;
	logic        in_stall;
	logic        out_valid;
	logic        kind;
	logic [7:0]  payload_byte;
	logic [7:0]  payload_index;
	logic [1:0]  status;
	logic [7:0]  command;
	logic [7:0]  length;

	rx_beat_t rx_beats[$];
	reply_t   expected_replies[$];
	int       beats_pushed   = 0;
	int       beats_accepted = 0;
	int       mismatches     = 0;
	int       quiet_cycles   = 0;
	int       idle_pct       = 15;
	int       tick_pct       = 0;

	srfp_pkg::parse_step_t frame_step;
	logic [7:0]  frame_cmd;
	logic [7:0]  frame_len;
	logic [7:0]  content_cnt;
	logic [7:0]  csum_acc;
	logic [15:0] tick_cnt;
	logic [7:0]  cfg_cmd;
	logic [15:0] cfg_timeout;

	servo_reply_frame_parser DUT (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.action(action),
		.data_byte(data_byte),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.kind(kind),
		.payload_byte(payload_byte),
		.payload_index(payload_index),
		.status(status),
		.command(command),
		.length(length)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	function automatic void clear_frame();
		frame_step  = srfp_pkg::ST_HUNT;
		frame_cmd   = '0;
		frame_len   = '0;
		content_cnt = '0;
		csum_acc    = '0;
		tick_cnt    = '0;
	endfunction

	function automatic logic parse_reply_beat(input logic act, input logic [7:0] b,
			output reply_t r);
		logic [1:0] st;
		r = '0;
		if (act == srfp_pkg::ACTION_TICK) begin
			if (tick_cnt < cfg_timeout)
				tick_cnt = tick_cnt + 16'd1;
			if (tick_cnt >= cfg_timeout) begin
				r.kind    = srfp_pkg::KIND_STATUS;
				r.status  = srfp_pkg::STATUS_TIMEOUT;
				r.command = frame_cmd;
				r.length  = frame_len;
				clear_frame();
				return 1'b1;
			end
			return 1'b0;
		end
		unique case (frame_step)
			srfp_pkg::ST_HDR2: begin
				if (b == srfp_pkg::HDR_SECOND) begin
					csum_acc   = csum_acc + b;
					frame_step = srfp_pkg::ST_CMD;
				end else begin
					frame_step = srfp_pkg::ST_HUNT;
				end
			end
			srfp_pkg::ST_CMD: begin
				frame_cmd  = b;
				csum_acc   = csum_acc + b;
				frame_step = srfp_pkg::ST_LEN;
			end
			srfp_pkg::ST_LEN: begin
				frame_len   = b;
				csum_acc    = csum_acc + b;
				content_cnt = '0;
				frame_step  = (b != 8'd0) ? srfp_pkg::ST_PAYLOAD : srfp_pkg::ST_CSUM;
			end
			srfp_pkg::ST_PAYLOAD: begin
				r.kind          = srfp_pkg::KIND_PAYLOAD;
				r.payload_byte  = b;
				r.payload_index = content_cnt;
				r.status        = srfp_pkg::STATUS_OK;
				r.command       = frame_cmd;
				r.length        = frame_len;
				csum_acc    = csum_acc + b;
				content_cnt = content_cnt + 8'd1;
				if (content_cnt >= frame_len)
					frame_step = srfp_pkg::ST_CSUM;
				return 1'b1;
			end
			srfp_pkg::ST_CSUM: begin
				if (csum_acc != b)
					st = srfp_pkg::STATUS_CSUM_ERR;
				else if (frame_cmd == cfg_cmd)
					st = srfp_pkg::STATUS_OK;
				else
					st = srfp_pkg::STATUS_CMD_ERR;
				r.kind    = srfp_pkg::KIND_STATUS;
				r.status  = st;
				r.command = frame_cmd;
				r.length  = frame_len;
				clear_frame();
				return 1'b1;
			end
			default: begin
				if (b == srfp_pkg::HDR_FIRST) begin
					frame_cmd   = '0;
					frame_len   = '0;
					content_cnt = '0;
					csum_acc    = b;
					frame_step  = srfp_pkg::ST_HDR2;
				end else begin
					frame_step = srfp_pkg::ST_HUNT;
				end
			end
		endcase
		return 1'b0;
	endfunction

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (got !== want) begin
			$error("%s expected %0h got %0h", name, want, got);
			mismatches++;
		end
	endtask

	task automatic push_beat(input logic act, input logic [7:0] b);
		rx_beats.push_back({act, b});
		beats_pushed++;
	endtask

	task automatic push_frame(input logic [7:0] cmd, input int len, input bit good);
		logic [7:0] seq[$];
		logic [7:0] sum;
		seq = '{srfp_pkg::HDR_FIRST, srfp_pkg::HDR_SECOND, cmd, len[7:0]};
		for (int i = 0; i < len; i++)
			seq.push_back(8'($urandom_range(255, 0)));
		sum = '0;
		foreach (seq[i])
			sum = sum + seq[i];
		seq.push_back(good ? sum : sum ^ 8'($urandom_range(255, 1)));
		foreach (seq[i]) begin
			if ($urandom_range(99, 0) < tick_pct)
				push_beat(srfp_pkg::ACTION_TICK, 8'($urandom_range(255, 0)));
			push_beat(srfp_pkg::ACTION_BYTE, seq[i]);
		end
	endtask

	task automatic apb_write(input logic reg_sel, input logic [31:0] value);
		logic [31:0] stored;
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {reg_sel, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (reg_sel == srfp_pkg::REG_EXPECTED_CMD) begin
			cfg_cmd = value[7:0];
			stored  = {24'd0, value[7:0]};
		end else begin
			cfg_timeout = value[15:0];
			stored      = {16'd0, value[15:0]};
		end
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata !== stored) begin
			$error("register %0d readback expected %0h got %0h", reg_sel, stored, prdata);
			mismatches++;
		end
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic settle();
		while (beats_accepted != beats_pushed || expected_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive
		rx_beat_t nb;
		reply_t   r;
		logic     fire;
		if (arst_n) begin
			fire = in_valid && !in_stall;
			if (fire) begin
				if (parse_reply_beat(action, data_byte, r))
					expected_replies.push_back(r);
				beats_accepted++;
			end
			if (fire || !in_valid) begin
				if (rx_beats.size() != 0 && $urandom_range(99, 0) >= idle_pct) begin
					nb = rx_beats.pop_front();
					in_valid  <= 1'b1;
					action    <= nb.action;
					data_byte <= nb.data;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : watch_replies
		reply_t want;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_replies.size() == 0) begin
					$error("unexpected reply beat, kind %0d status %0d", kind, status);
					mismatches++;
				end else begin
					want = expected_replies.pop_front();
					check_field("kind", 16'(want.kind), 16'(kind));
					check_field("payload_byte", 16'(want.payload_byte), 16'(payload_byte));
					check_field("payload_index", 16'(want.payload_index),
						16'(payload_index));
					check_field("status", 16'(want.status), 16'(status));
					check_field("command", 16'(want.command), 16'(command));
					check_field("length", 16'(want.length), 16'(length));
				end
			end
			out_stall <= ($urandom_range(99, 0) < idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("SCOREBOARD MISMATCH");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	initial begin : stimulus
		logic [7:0]  seq[$];
		logic [31:0] rnd;
		logic [7:0]  b;
		logic [7:0]  new_cmd;
		logic [15:0] new_timeout;
		int          start;
		int          pick;
		int          len;
		cfg_cmd     = 8'd0;
		cfg_timeout = srfp_pkg::TIMEOUT_RESET;
		clear_frame();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		// Good empty frame, then a wrong second header byte right after a first one.
		seq = '{8'h05, 8'h1C, 8'h00, 8'h00, 8'h21, 8'h05, 8'h05, 8'h1C};
		foreach (seq[i])
			push_beat(srfp_pkg::ACTION_BYTE, seq[i]);
		push_beat(srfp_pkg::ACTION_TICK, 8'h00);
		push_beat(srfp_pkg::ACTION_TICK, 8'hFF);
		// Both command and checksum wrong, then a command mismatch with a good checksum.
		seq = '{8'h05, 8'h1C, 8'hFF, 8'h02, 8'h00, 8'hFF, 8'h20,
			8'h05, 8'h1C, 8'h01, 8'h01, 8'hAA, 8'hCD};
		foreach (seq[i])
			push_beat(srfp_pkg::ACTION_BYTE, seq[i]);
		settle();

		apb_write(srfp_pkg::REG_EXPECTED_CMD, 32'h0000_00FF);
		apb_write(srfp_pkg::REG_TIMEOUT, 32'h0000_0000);
		push_beat(srfp_pkg::ACTION_TICK, 8'h5A);
		push_beat(srfp_pkg::ACTION_BYTE, srfp_pkg::HDR_FIRST);
		push_beat(srfp_pkg::ACTION_TICK, 8'hA5);
		settle();

		for (int p = 0; p < 6; p++) begin
			new_cmd     = 8'($urandom_range(255, 0));
			new_timeout = 16'($urandom_range(200, 2));
			tick_pct    = 5;
			idle_pct    = 15;
			unique case (p)
				0: begin
					new_cmd     = 8'hFF;
					new_timeout = 16'hFFFF;
					tick_pct    = 10;
				end
				1: begin
					new_cmd     = 8'h00;
					new_timeout = 16'd1;
					tick_pct    = 3;
				end
				2: begin
					new_timeout = 16'($urandom_range(30, 5));
					tick_pct    = 8;
				end
				3: begin
					new_timeout = srfp_pkg::TIMEOUT_RESET;
					idle_pct    = 0;
				end
				4: begin
					new_timeout = 16'd0;
					tick_pct    = 2;
				end
				default: begin
				end
			endcase
			rnd = $urandom();
			rnd[7:0] = new_cmd;
			apb_write(srfp_pkg::REG_EXPECTED_CMD, rnd);
			rnd = $urandom();
			rnd[15:0] = new_timeout;
			apb_write(srfp_pkg::REG_TIMEOUT, rnd);

			if (p == 3)
				push_frame(cfg_cmd, 255, 1'b1);
			start = beats_pushed;
			while (beats_pushed - start < 80) begin
				pick = $urandom_range(99, 0);
				if (pick < 75) begin
					len = ($urandom_range(9, 0) == 0) ? $urandom_range(40, 7)
						: $urandom_range(6, 0);
					push_frame(($urandom_range(4, 0) == 0) ? 8'($urandom_range(255, 0))
						: cfg_cmd, len, $urandom_range(6, 0) != 0);
				end else if (pick < 80) begin
					b = 8'($urandom_range(255, 0));
					if (b == srfp_pkg::HDR_SECOND)
						b = srfp_pkg::HDR_FIRST;
					push_beat(srfp_pkg::ACTION_BYTE, srfp_pkg::HDR_FIRST);
					push_beat(srfp_pkg::ACTION_BYTE, b);
				end else if (pick < 85) begin
					push_beat(srfp_pkg::ACTION_BYTE, srfp_pkg::HDR_FIRST);
					push_beat(srfp_pkg::ACTION_BYTE, srfp_pkg::HDR_SECOND);
					push_beat(srfp_pkg::ACTION_BYTE, 8'($urandom_range(255, 0)));
				end else begin
					push_beat(1'($urandom_range(1, 0)), 8'($urandom_range(255, 0)));
				end
			end
			settle();
		end

		settle();
		if (mismatches == 0 && expected_replies.size() == 0) begin
			$display("SCOREBOARD CLEAN");
		end else begin
			$display("SCOREBOARD MISMATCH");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hdl/srfp_pkg.sv
hdl/srfp_core.sv
hdl/servo_reply_frame_parser.sv
sim/tb_servo_reply_frame_parser.sv
